// ===== rtl/ist_pkg.sv =====
// Package for the integer set table: sizes, opcodes, status codes and
// the write-control struct passed from the top level to each cell.
// No dependencies.
`default_nettype none
package ist_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int OUT_CNT_W = 5;

	localparam logic [1:0] OP_QUERY  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DUP    = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	// Write controls broadcast to the cell row for one accepted beat.
	typedef struct packed {
		logic ins_we;   // insert goes to the tail cell
		logic rem_we;   // remove: cells at/after the hit take the neighbor entry
	} ist_wr_t;

endpackage
`default_nettype wire

// ===== rtl/ist_req_if.sv =====
// Request channel: valid/ready handshake carrying opcode and value.
// Depends on nothing.
`default_nettype none
interface ist_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  opcode;
	logic signed [31:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/ist_rsp_if.sv =====
// Response channel: valid/ready handshake carrying found, status and count.
// Depends on nothing.
`default_nettype none
interface ist_rsp_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [1:0] status;
	logic [4:0] count;

	modport source (output valid, output found, output status, output count, input ready);
	modport sink   (input valid, input found, input status, input count, output ready);
endinterface
`default_nettype wire

// ===== rtl/integer_set_table.sv =====
// Integer set table top level: row of ist_cell slots, fill count and
// response register. Uses ist_pkg, ist_req_if, ist_rsp_if, ist_cell.
//
//   channel | dir | fields                      | handshake
//   req     | in  | opcode[1:0], value[31:0]    | valid/ready
//   rsp     | out | found, status[1:0], count[4:0] | valid/ready
//
// Each request is resolved in the cycle it is accepted: all cells compare in
// parallel and the hit ripples up the cell row to steer the remove shift.
// One request per cycle unless rsp stalls; the response is registered.
// req.ready drops only while a response is held and rsp.ready is low.
// arst_n empties the set; entries themselves are not reset.
`default_nettype none
module integer_set_table (
	input  wire logic clk,
	input  wire logic arst_n,
	ist_req_if.sink   req,
	ist_rsp_if.source rsp
);

	localparam int N = ist_pkg::CAPACITY;

	logic [ist_pkg::CNT_W-1:0] cnt_q;
	logic                      rsp_valid_q;
	logic                      rsp_found_q;
	logic [1:0]                rsp_status_q;

	logic                      fire;
	logic [N-1:0]              occ;
	logic [N-1:0]              tail;
	logic [N-1:0]              hit;
	logic [N:0]                match;
	logic [ist_pkg::VAL_W-1:0] entry [N];
	logic                      found;
	logic                      full;
	ist_pkg::ist_wr_t          wr;
	logic [ist_pkg::CNT_W-1:0] cnt_d;
	logic [1:0]                status_d;
	logic [ist_pkg::CNT_W+ist_pkg::OUT_CNT_W-1:0] cnt_ext;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	assign match[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign occ[i]  = ist_pkg::CNT_W'(i) < cnt_q;
		assign tail[i] = ist_pkg::CNT_W'(i) == cnt_q;

		logic [ist_pkg::VAL_W-1:0] nxt;
		if (i == N - 1) begin : g_last
			assign nxt = entry[i];
		end else begin : g_mid
			assign nxt = entry[i+1];
		end

		ist_cell u_cell (
			.clk        (clk),
			.value      (req.value),
			.occupied   (occ[i]),
			.tail       (tail[i]),
			.wr         (wr),
			.match_in   (match[i]),
			.next_entry (nxt),
			.entry      (entry[i]),
			.hit        (hit[i]),
			.match_out  (match[i+1])
		);
	end

	assign found = match[N];
	assign full  = cnt_q == ist_pkg::CNT_W'(N);

	always_comb begin
		wr.ins_we = 1'b0;
		wr.rem_we = 1'b0;
		cnt_d     = cnt_q;
		status_d  = ist_pkg::ST_OK;
		unique case (req.opcode)
			ist_pkg::OP_QUERY: begin
				status_d = found ? ist_pkg::ST_OK : ist_pkg::ST_ABSENT;
			end
			ist_pkg::OP_INSERT: begin
				if (found) begin
					status_d = ist_pkg::ST_DUP;
				end else if (full) begin
					status_d = ist_pkg::ST_FULL;
				end else begin
					wr.ins_we = fire;
					cnt_d     = cnt_q + 1'b1;
				end
			end
			ist_pkg::OP_REMOVE: begin
				if (!found) begin
					status_d = ist_pkg::ST_ABSENT;
				end else begin
					wr.rem_we = fire;
					cnt_d     = cnt_q - 1'b1;
				end
			end
			ist_pkg::OP_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
				cnt_d = cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				cnt_q <= cnt_d;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// clear reports found low regardless of the value
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_found_q  <= found && (req.opcode != ist_pkg::OP_CLEAR);
			rsp_status_q <= status_d;
		end
	end

	assign cnt_ext    = {{ist_pkg::OUT_CNT_W{1'b0}}, cnt_q};
	assign rsp.valid  = rsp_valid_q;
	assign rsp.found  = rsp_found_q;
	assign rsp.status = rsp_status_q;
	assign rsp.count  = cnt_ext[ist_pkg::OUT_CNT_W-1:0];

	// entries are distinct, so at most one cell can hit
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(hit))
		else $error("more than one cell matched");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ist_pkg::CNT_W'(N))
		else $error("fill count above capacity");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.opcode == ist_pkg::OP_CLEAR) |=> cnt_q == '0)
		else $error("clear did not empty the set");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(fire))
		else $error("response without accepted request");

endmodule
`default_nettype wire

// ===== rtl/ist_cell.sv =====
// One table slot: holds an entry, compares it with the request value and
// takes either the inserted value or its upper neighbor's entry. Uses ist_pkg.
`default_nettype none
module ist_cell (
	input  wire logic                        clk,
	input  wire logic [ist_pkg::VAL_W-1:0]   value,
	input  wire logic                        occupied,
	input  wire logic                        tail,
	input  wire ist_pkg::ist_wr_t            wr,
	input  wire logic                        match_in,
	input  wire logic [ist_pkg::VAL_W-1:0]   next_entry,
	output logic      [ist_pkg::VAL_W-1:0]   entry,
	output logic                             hit,
	output logic                             match_out
);

	logic [ist_pkg::VAL_W-1:0] entry_q;

	assign entry     = entry_q;
	assign hit       = occupied && (entry_q == value);
	assign match_out = match_in || hit;

	always_ff @(posedge clk) begin
		if (wr.ins_we && tail) begin
			entry_q <= value;
		end else if (wr.rem_we && match_out) begin
			entry_q <= next_entry;
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/integer_set_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the integer set table: follows both channels, keeps its own copy
// of the set and checks every response beat field by field.
// Depends on ist_pkg, ist_req_if and ist_rsp_if.
module integer_set_checker
	import ist_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	ist_req_if        req_mon,
	ist_rsp_if        rsp_mon,
	output int        fail_count,
	output int        pending
);

	typedef struct packed {
		logic       found;
		logic [1:0] status;
		logic [4:0] count;
	} set_reply_t;

	logic signed [VAL_W-1:0] members [CAPACITY];
	int                      member_cnt = 0;
	int                      fail_tally = 0;
	set_reply_t              reply_q [$];

	// Apply one request to the shadow set and return the reply it should give.
	function automatic set_reply_t apply_request(logic [1:0] op, logic signed [VAL_W-1:0] val);
		set_reply_t r;
		int         hit;
		r   = '0;
		hit = -1;
		if (op == OP_CLEAR) begin
			member_cnt = 0;
		end else begin
			for (int i = 0; i < member_cnt; i++)
				if (hit < 0 && members[i] == val)
					hit = i;
			r.found = (hit >= 0);
			case (op)
				OP_QUERY: begin
					r.status = r.found ? ST_OK : ST_ABSENT;
				end
				OP_INSERT: begin
					// duplicate wins over full
					if (r.found) begin
						r.status = ST_DUP;
					end else if (member_cnt >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						members[member_cnt] = val;
						member_cnt++;
					end
				end
				default: begin
					if (!r.found) begin
						r.status = ST_ABSENT;
					end else begin
						for (int j = hit; j < member_cnt - 1; j++)
							members[j] = members[j + 1];
						member_cnt--;
					end
				end
			endcase
		end
		r.count = OUT_CNT_W'(member_cnt);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		set_reply_t want;
		if (!arst_n) begin
			member_cnt = 0;
			reply_q.delete();
			pending    <= 0;
			fail_count <= fail_tally;
		end else begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (reply_q.size() == 0) begin
					$error("rsp: beat with no request outstanding");
					fail_tally++;
				end else begin
					want = reply_q.pop_front();
					if (rsp_mon.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp_mon.found);
						fail_tally++;
					end
					if (rsp_mon.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_mon.status);
						fail_tally++;
					end
					if (rsp_mon.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp_mon.count);
						fail_tally++;
					end
				end
			end
			if (req_mon.valid && req_mon.ready)
				reply_q.push_back(apply_request(req_mon.opcode, req_mon.value));
			pending    <= reply_q.size();
			fail_count <= fail_tally;
		end
	end

endmodule

// ===== tb/sv/integer_set_table_test.sv =====
`timescale 1ns / 100ps
// Top of the integer set table testbench: clock, reset, request and response
// traffic, verdict. Depends on ist_pkg, both channel interfaces, the block and
// integer_set_checker.
module integer_set_table_test;
	import ist_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on;
	int   fail_count;
	int   pending;
	logic signed [VAL_W-1:0] pool [24];

	ist_req_if req_ch ();
	ist_rsp_if rsp_ch ();

	integer_set_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	integer_set_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_mon    (req_ch),
		.rsp_mon    (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Response side stalls in bursts while idling is on.
	initial begin
		int gap;
		rsp_ch.ready = 1'b1;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 18);
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic drive_req(logic [1:0] op, logic signed [VAL_W-1:0] val);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= op;
		req_ch.value  <= val;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_replies();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		int                      pick;
		logic [1:0]              op;
		logic signed [VAL_W-1:0] val;
		arst_n        = 1'b0;
		idle_on       = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.opcode = OP_QUERY;
		req_ch.value  = '0;
		pool[0] = 32'sh8000_0000;
		pool[1] = 32'sh7fff_ffff;
		pool[2] = 32'sd0;
		pool[3] = -32'sd1;
		for (int i = 4; i < 24; i++)
			pool[i] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty set, extremes, duplicate, middle remove, fill, full, dup on full
		idle_on = 1'b1;
		drive_req(OP_CLEAR, $urandom);
		drive_req(OP_QUERY, 32'sd0);
		drive_req(OP_REMOVE, 32'sd5);
		drive_req(OP_INSERT, 32'sh8000_0000);
		drive_req(OP_INSERT, 32'sh7fff_ffff);
		drive_req(OP_INSERT, 32'sd0);
		drive_req(OP_INSERT, -32'sd1);
		drive_req(OP_INSERT, 32'sh7fff_ffff);
		drive_req(OP_QUERY, -32'sd1);
		drive_req(OP_REMOVE, 32'sd0);
		drive_req(OP_REMOVE, 32'sd0);
		drive_req(OP_QUERY, -32'sd1);
		for (int k = 0; k < 13; k++)
			drive_req(OP_INSERT, k * 32'sh1111_1111);
		drive_req(OP_INSERT, 32'sh7ead_beef);
		drive_req(OP_INSERT, 32'sh8000_0000);
		drive_req(OP_REMOVE, 32'sh8000_0000);
		drive_req(OP_INSERT, 32'sh7ead_beef);
		drive_req(OP_CLEAR, $urandom);
		drain_replies();

		// random: values mostly from a small pool so hits, dups and full tables are common
		for (int blk = 0; blk < 15; blk++) begin
			idle_on = (blk < 13) ? ($urandom_range(0, 3) != 0) : 1'b0;
			if (blk == 7)
				drain_replies();
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 19) == 0)
					pool[$urandom_range(4, 23)] = $urandom;
				pick = $urandom_range(0, 99);
				val  = (pick < 85) ? pool[$urandom_range(0, 23)] : $signed($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 3)
					op = OP_CLEAR;
				else if (pick < 33)
					op = OP_QUERY;
				else if (pick < 75)
					op = OP_INSERT;
				else
					op = OP_REMOVE;
				drive_req(op, val);
			end
		end

		drain_replies();
		repeat (4) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
